[rtl/core/rrc_pkg.sv]
// rrc_pkg: shared types and constants for the rectangle raster canvas core
// holds function codes, register indexes, fsm encoding and the bound/cover structs
// no dependencies
package rrc_pkg;

  // fixed point: 8 fraction bits, one unit is 256
  localparam int FRAC_W   = 8;
  localparam int ONE_UNIT = 256;

  // widths fixed by the item fields
  localparam int COORD_W = 24;
  localparam int CFG_W   = 9;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 2;

  // internal coordinate width, holds any edge sum and difference
  localparam int D_W = 27;

  // shape type bytes
  localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h72;
  localparam logic [CHAR_W-1:0] SHAPE_FILLED  = 8'h52;

  // function codes
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_BG     = 2'd2;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0]  WIDTH_RST  = 9'd300;
  localparam logic [CFG_W-1:0]  HEIGHT_RST = 9'd300;
  localparam logic [CHAR_W-1:0] BG_RST     = 8'd32;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_READ  = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  // closed rectangle edges in fixed point
  typedef struct packed {
    logic signed [D_W-1:0] x0;
    logic signed [D_W-1:0] x1;
    logic signed [D_W-1:0] y0;
    logic signed [D_W-1:0] y1;
  } bounds_t;

  // cover class of one cell
  typedef struct packed {
    logic covered;
    logic border;
  } cover_t;

endpackage

[rtl/core/rrc_cover.sv]
// rrc_cover: classifies one canvas cell against a rectangle (outside, interior, border)
// depends on rrc_pkg for bounds_t, cover_t and the fixed point constants
module rrc_cover import rrc_pkg::*; #(
  parameter int CW = 9
) (
  input  logic [CW-1:0] col,
  input  logic [CW-1:0] row,
  input  bounds_t       bounds,
  output cover_t        cov
);

  logic signed [D_W-1:0] px;
  logic signed [D_W-1:0] py;
  logic signed [D_W-1:0] dx0;
  logic signed [D_W-1:0] dx1;
  logic signed [D_W-1:0] dy0;
  logic signed [D_W-1:0] dy1;
  logic signed [D_W-1:0] unit;

  // cell position in fixed point
  assign px   = $signed({{(D_W-CW-FRAC_W){1'b0}}, col, {FRAC_W{1'b0}}});
  assign py   = $signed({{(D_W-CW-FRAC_W){1'b0}}, row, {FRAC_W{1'b0}}});
  assign unit = $signed(D_W'(ONE_UNIT));

  // distances to each edge
  assign dx0 = px - bounds.x0;
  assign dx1 = bounds.x1 - px;
  assign dy0 = py - bounds.y0;
  assign dy1 = bounds.y1 - py;

  // inside the closed rectangle, border when under one unit from an edge
  assign cov.covered = !dx0[D_W-1] && !dx1[D_W-1] && !dy0[D_W-1] && !dy1[D_W-1];
  assign cov.border  = (dx0 < unit) || (dx1 < unit) || (dy0 < unit) || (dy1 < unit);

endmodule

[rtl/core/rectangle_raster_canvas_core.sv]
// rectangle_raster_canvas_core: character canvas with clear, rectangle draw and cell read
// depends on rrc_pkg and rrc_cover; the canvas memory lives here
//
//   channel   ports                                               transfer
//   command   start, busy, func, shape_type, rect_*, paint_char,  start && !busy
//             cell_row, cell_col
//   result    done, cell_value, status                            done (one cycle)
//   config    cfg_we, cfg_index, cfg_data                         cfg_we
//
// clear and draw sweep the canvas in use at one cell per cycle through the single
// memory write port, then give the result. a rejected draw or unused code goes straight to the result.
// a read passes address capture, the registered memory read and the result.
// reset clears control and configuration only; the canvas is not cleared.
// busy stays high until the result cycle has passed; the result cannot be stalled.
module rectangle_raster_canvas_core import rrc_pkg::*; #(
  parameter int MAX_SIDE = 300
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func,
  input  logic [CHAR_W-1:0]         shape_type,
  input  logic signed [COORD_W-1:0] rect_left,
  input  logic signed [COORD_W-1:0] rect_top,
  input  logic signed [COORD_W-1:0] rect_span_x,
  input  logic signed [COORD_W-1:0] rect_span_y,
  input  logic [CHAR_W-1:0]         paint_char,
  input  logic [CFG_W-1:0]          cell_row,
  input  logic [CFG_W-1:0]          cell_col,
  output logic                      done,
  output logic [CHAR_W-1:0]         cell_value,
  output logic                      status,
  input  logic                      cfg_we,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int CMP_W   = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

  // configuration registers
  logic [CFG_W-1:0]  canvas_width;
  logic [CFG_W-1:0]  canvas_height;
  logic [CHAR_W-1:0] background_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= WIDTH_RST;
      canvas_height   <= HEIGHT_RST;
      background_char <= BG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  canvas_width    <= cfg_data;
        REG_HEIGHT: canvas_height   <= cfg_data;
        REG_BG:     background_char <= cfg_data[CHAR_W-1:0];
        default:    ;
      endcase
    end
  end

  // sides in use, clamped to 1..MAX_SIDE
  logic [CMP_W-1:0] w_use;
  logic [CMP_W-1:0] h_use;

  always_comb begin
    if (canvas_width == '0) begin
      w_use = CMP_W'(1);
    end else if (CMP_W'(canvas_width) > CMP_W'(MAX_SIDE)) begin
      w_use = CMP_W'(MAX_SIDE);
    end else begin
      w_use = CMP_W'(canvas_width);
    end
    if (canvas_height == '0) begin
      h_use = CMP_W'(1);
    end else if (CMP_W'(canvas_height) > CMP_W'(MAX_SIDE)) begin
      h_use = CMP_W'(MAX_SIDE);
    end else begin
      h_use = CMP_W'(canvas_height);
    end
  end

  state_t state;
  state_t state_next;

  logic              accept;
  logic              draw_ok;
  logic              shape_known;
  logic              filled;
  logic              sweep_fill;
  logic [CHAR_W-1:0] sweep_char;
  bounds_t           bounds;
  logic [CW-1:0]     col;
  logic [CW-1:0]     row;
  logic [CW-1:0]     col_last;
  logic [CW-1:0]     row_last;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_ok;
  logic              resp_read;
  logic              resp_status;
  logic [CHAR_W-1:0] rd_data;
  logic              sweep_end;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  cover_t            cov;

  assign accept      = start && (state == ST_IDLE);
  assign busy        = (state != ST_IDLE);
  assign shape_known = (shape_type == SHAPE_FILLED) || (shape_type == SHAPE_OUTLINE);
  assign draw_ok     = shape_known && !rect_span_x[COORD_W-1] && (rect_span_x != '0)
                       && !rect_span_y[COORD_W-1] && (rect_span_y != '0);
  assign sweep_end   = (col == col_last) && (row == row_last);

  // control state machine
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (func)
            FUNC_CLEAR: state_next = ST_SWEEP;
            FUNC_DRAW:  state_next = draw_ok ? ST_SWEEP : ST_RESP;
            FUNC_READ:  state_next = ST_READ;
            default:    state_next = ST_RESP;
          endcase
        end
      end
      ST_SWEEP: if (sweep_end) state_next = ST_RESP;
      ST_READ:  state_next = ST_RESP;
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture at the command transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      sweep_fill  <= (func == FUNC_CLEAR);
      sweep_char  <= (func == FUNC_CLEAR) ? background_char : paint_char;
      filled      <= (shape_type == SHAPE_FILLED);
      bounds.x0   <= D_W'(rect_left);
      bounds.y0   <= D_W'(rect_top);
      bounds.x1   <= D_W'(rect_left) + D_W'(rect_span_x);
      bounds.y1   <= D_W'(rect_top) + D_W'(rect_span_y);
      col_last    <= CW'(w_use - CMP_W'(1));
      row_last    <= CW'(h_use - CMP_W'(1));
      resp_read   <= (func == FUNC_READ);
      resp_status <= (func == FUNC_DRAW) && !draw_ok;
      rd_ok       <= (CMP_W'(cell_row) < h_use) && (CMP_W'(cell_col) < w_use);
      rd_addr     <= ADDR_W'(ADDR_W'(cell_row) * ADDR_W'(MAX_SIDE)) + ADDR_W'(cell_col);
    end
  end

  // raster scan counters, row base kept as a running sum
  always_ff @(posedge clk) begin
    if (accept) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (state == ST_SWEEP) begin
      if (col == col_last) begin
        col      <= '0;
        row      <= row + CW'(1);
        row_base <= row_base + ADDR_W'(MAX_SIDE);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  rrc_cover #(
    .CW (CW)
  ) u_cover (
    .col    (col),
    .row    (row),
    .bounds (bounds),
    .cov    (cov)
  );

  // paint decision for the current cell
  assign wr_addr = row_base + ADDR_W'(col);
  assign wr_en   = (state == ST_SWEEP)
                   && (sweep_fill || (cov.covered && (filled || cov.border)));

  // canvas memory, one write and one registered read port
  logic [CHAR_W-1:0] canvas [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      canvas[wr_addr] <= sweep_char;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_data <= canvas[rd_addr];
    end
  end

  // result
  assign done       = (state == ST_RESP);
  assign status     = resp_status;
  assign cell_value = (resp_read && rd_ok) ? rd_data : '0;

endmodule

[rtl/core/rrc_checker.sv]
// rrc_checker: port level checks on the command and result handshake of the canvas core
// depends on rectangle_raster_canvas_core (bound to it at the end of this file)
module rrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       status,
  input logic [7:0] cell_value
);

  // an accepted command sets the core busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("core not busy after command transfer");

  // a result belongs to a command in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result while idle");

  // exactly one result per command, then free again
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result repeated or core still busy after result");

  // a rejected shape carries no character
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && status |-> cell_value == 8'd0)
    else $error("rejected draw returned a character");

endmodule

bind rectangle_raster_canvas_core rrc_checker u_rrc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .cell_value (cell_value)
);

[bench/tb_rectangle_raster_canvas_core.sv]
`timescale 1ns / 1ps
// tb_rectangle_raster_canvas_core: self-checking bench for the rectangle raster canvas core
// depends on rrc_pkg and rectangle_raster_canvas_core; a scoreboard class mirrors the
// canvas and registers, predicts each result and checks what the core returns
module tb_rectangle_raster_canvas_core;
  import rrc_pkg::*;

  localparam int SIDE = 300;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CHAR_W-1:0] SHAPE_UNKNOWN = 8'h78;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 10;

  // one command as seen on the command channel
  typedef struct {
    logic [1:0]                func;
    logic [CHAR_W-1:0]         shape;
    logic signed [COORD_W-1:0] left, top, span_x, span_y;
    logic [CHAR_W-1:0]         paint;
    logic [CFG_W-1:0]          row, col;
  } canvas_cmd_t;

  // one result as seen on the result channel
  typedef struct {
    logic [CHAR_W-1:0] value;
    logic              flag;
  } canvas_reply_t;

  // mirror of the canvas and its registers, with the queue of replies still due
  class raster_scoreboard;
    bit [CHAR_W-1:0] cells [SIDE*SIDE];
    bit [CFG_W-1:0]  width_reg, height_reg;
    bit [CHAR_W-1:0] bg_reg;
    canvas_reply_t   pending_replies[$];
    int mismatches, replies_checked, reg_writes;
    int clears, draws, rejects, reads, unused_ops;

    function new();
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      bg_reg = BG_RST;
      mismatches = 0;
      replies_checked = 0;
      reg_writes = 0;
      clears = 0;
      draws = 0;
      rejects = 0;
      reads = 0;
      unused_ops = 0;
    endfunction

    // zero counts as one, anything past the array size is clamped
    function int side_used(bit [CFG_W-1:0] r);
      if (r == 0) return 1;
      if (r > SIDE) return SIDE;
      return r;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_WIDTH:  width_reg = data;
        REG_HEIGHT: height_reg = data;
        REG_BG:     bg_reg = data[CHAR_W-1:0];
        default: ;
      endcase
    endfunction

    // apply one accepted command and queue the reply it must produce
    function void note_command(canvas_cmd_t cmd);
      int w, h, r, c;
      longint x0, y0, x1, y1, px, py;
      bit filled, outline, near_side;
      canvas_reply_t rep;
      w = side_used(width_reg);
      h = side_used(height_reg);
      rep.value = '0;
      rep.flag = 1'b0;
      case (cmd.func)
        FUNC_CLEAR: begin
          clears++;
          for (r = 0; r < h; r++)
            for (c = 0; c < w; c++)
              cells[r*SIDE+c] = bg_reg;
        end
        FUNC_DRAW: begin
          filled = (cmd.shape == SHAPE_FILLED);
          outline = (cmd.shape == SHAPE_OUTLINE);
          if (cmd.span_x <= 0 || cmd.span_y <= 0 || !(filled || outline)) begin
            rep.flag = 1'b1;
            rejects++;
          end else begin
            draws++;
            x0 = cmd.left;
            y0 = cmd.top;
            x1 = x0 + cmd.span_x;
            y1 = y0 + cmd.span_y;
            for (r = 0; r < h; r++) begin
              for (c = 0; c < w; c++) begin
                px = c * ONE_UNIT;
                py = r * ONE_UNIT;
                if (px >= x0 && px <= x1 && py >= y0 && py <= y1) begin
                  // border cells lie less than one unit from some edge
                  near_side = (px - x0 < ONE_UNIT) || (x1 - px < ONE_UNIT) ||
                              (py - y0 < ONE_UNIT) || (y1 - py < ONE_UNIT);
                  if (filled || near_side) cells[r*SIDE+c] = cmd.paint;
                end
              end
            end
          end
        end
        FUNC_READ: begin
          reads++;
          if (cmd.row < h && cmd.col < w) rep.value = cells[cmd.row*SIDE+cmd.col];
        end
        default: unused_ops++;
      endcase
      pending_replies.push_back(rep);
    endfunction

    function void check_reply(logic [CHAR_W-1:0] value, logic flag);
      canvas_reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding: cell_value=%0d status=%0d",
                   $time, value, flag);
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      if (value !== want.value) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: cell_value expected %0d, got %0d", $time, want.value, value);
      end
      if (flag !== want.flag) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: status expected %0d, got %0d", $time, want.flag, flag);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [1:0]                func;
  logic [CHAR_W-1:0]         shape_type;
  logic signed [COORD_W-1:0] rect_left;
  logic signed [COORD_W-1:0] rect_top;
  logic signed [COORD_W-1:0] rect_span_x;
  logic signed [COORD_W-1:0] rect_span_y;
  logic [CHAR_W-1:0]         paint_char;
  logic [CFG_W-1:0]          cell_row;
  logic [CFG_W-1:0]          cell_col;
  logic                      done;
  logic [CHAR_W-1:0]         cell_value;
  logic                      status;
  logic                      cfg_we;
  logic [IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  raster_scoreboard sb;
  canvas_cmd_t      seen;
  int               stall_cycles;
  bit               steady_feed;
  int               use_w, use_h;

  rectangle_raster_canvas_core #(
    .MAX_SIDE(SIDE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .shape_type(shape_type),
    .rect_left(rect_left),
    .rect_top(rect_top),
    .rect_span_x(rect_span_x),
    .rect_span_y(rect_span_y),
    .paint_char(paint_char),
    .cell_row(cell_row),
    .cell_col(cell_col),
    .done(done),
    .cell_value(cell_value),
    .status(status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // monitor: register writes, command transfers and results, all at one edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) begin
        seen.func = func;
        seen.shape = shape_type;
        seen.left = rect_left;
        seen.top = rect_top;
        seen.span_x = rect_span_x;
        seen.span_y = rect_span_y;
        seen.paint = paint_char;
        seen.row = cell_row;
        seen.col = cell_col;
        sb.note_command(seen);
      end
      if (done) sb.check_reply(cell_value, status);
      if (cfg_we || (start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_rectangle_raster_canvas_core: errors");
    $finish;
  end

  // random filler for the fields a command does not use
  function automatic canvas_cmd_t scrambled_cmd(logic [1:0] f);
    canvas_cmd_t cmd;
    cmd.func = f;
    cmd.shape = CHAR_W'($urandom_range(0, 255));
    cmd.left = COORD_W'($urandom);
    cmd.top = COORD_W'($urandom);
    cmd.span_x = COORD_W'($urandom);
    cmd.span_y = COORD_W'($urandom);
    cmd.paint = CHAR_W'($urandom_range(0, 255));
    cmd.row = CFG_W'($urandom_range(0, SIDE - 1));
    cmd.col = CFG_W'($urandom_range(0, SIDE - 1));
    return cmd;
  endfunction

  // one command transfer, with a random gap in front unless feeding steadily
  task automatic send_item(canvas_cmd_t cmd);
    int gap;
    gap = steady_feed ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= cmd.func;
    shape_type <= cmd.shape;
    rect_left <= cmd.left;
    rect_top <= cmd.top;
    rect_span_x <= cmd.span_x;
    rect_span_y <= cmd.span_y;
    paint_char <= cmd.paint;
    cell_row <= cmd.row;
    cell_col <= cmd.col;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_clear();
    send_item(scrambled_cmd(FUNC_CLEAR));
  endtask

  task automatic send_unused();
    send_item(scrambled_cmd(FUNC_UNUSED));
  endtask

  task automatic send_read(logic [CFG_W-1:0] row, logic [CFG_W-1:0] col);
    canvas_cmd_t cmd;
    cmd = scrambled_cmd(FUNC_READ);
    cmd.row = row;
    cmd.col = col;
    send_item(cmd);
  endtask

  task automatic send_draw(logic [CHAR_W-1:0] shape, logic signed [COORD_W-1:0] l,
                           logic signed [COORD_W-1:0] t, logic signed [COORD_W-1:0] sx,
                           logic signed [COORD_W-1:0] sy, logic [CHAR_W-1:0] paint);
    canvas_cmd_t cmd;
    cmd = scrambled_cmd(FUNC_DRAW);
    cmd.shape = shape;
    cmd.left = l;
    cmd.top = t;
    cmd.span_x = sx;
    cmd.span_y = sy;
    cmd.paint = paint;
    send_item(cmd);
  endtask

  // hold off commands until every reply is in and the core has gone idle
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_replies.size() != 0 || busy);
    repeat (2) @(posedge clk);
  endtask

  // write all three registers back to back; only called while idle
  task automatic setup_canvas(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                              logic [CHAR_W-1:0] bg);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= REG_BG;
    cfg_data <= {1'b0, bg};
    @(posedge clk);
    cfg_we <= 1'b0;
    use_w = (w == 0) ? 1 : (w > SIDE) ? SIDE : w;
    use_h = (h == 0) ? 1 : (h > SIDE) ? SIDE : h;
  endtask

  // mostly well-formed rectangles around the canvas, some broken, some pure noise
  task automatic send_random_draw();
    int roll, l, t, sx, sy;
    logic [CHAR_W-1:0] kind;
    roll = $urandom_range(0, 99);
    kind = (roll < 47) ? SHAPE_FILLED : (roll < 94) ? SHAPE_OUTLINE :
           CHAR_W'($urandom_range(0, 255));
    l = $urandom_range(0, (use_w + 4) * ONE_UNIT) - 2 * ONE_UNIT;
    t = $urandom_range(0, (use_h + 4) * ONE_UNIT) - 2 * ONE_UNIT;
    sx = $urandom_range(1, (use_w + 2) * ONE_UNIT);
    sy = $urandom_range(1, (use_h + 2) * ONE_UNIT);
    // whole-unit edges land exactly on cell centres
    if ($urandom_range(0, 2) == 0) begin
      l = l & ~(ONE_UNIT - 1);
      t = t & ~(ONE_UNIT - 1);
      sx = sx & ~(ONE_UNIT - 1);
      sy = sy & ~(ONE_UNIT - 1);
    end
    roll = $urandom_range(0, 99);
    if (roll < 6) sx = 0 - int'($urandom_range(0, 2000));
    else if (roll < 12) sy = 0 - int'($urandom_range(0, 2000));
    else if (roll < 16) begin
      l = $urandom;
      t = $urandom;
      sx = $urandom;
      sy = $urandom;
    end
    send_draw(kind, COORD_W'(l), COORD_W'(t), COORD_W'(sx), COORD_W'(sy),
              CHAR_W'($urandom_range(0, 255)));
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 42) send_random_draw();
    else if (pick < 88) begin
      if ($urandom_range(0, 3) != 0)
        send_read(CFG_W'($urandom_range(0, use_h - 1)), CFG_W'($urandom_range(0, use_w - 1)));
      else
        send_read(CFG_W'($urandom_range(0, SIDE - 1)), CFG_W'($urandom_range(0, SIDE - 1)));
    end
    else if (pick < 94) send_clear();
    else send_unused();
  endtask

  // stimulus
  initial begin
    int p, wreg, hreg;
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    func <= FUNC_CLEAR;
    shape_type <= '0;
    rect_left <= '0;
    rect_top <= '0;
    rect_span_x <= '0;
    rect_span_y <= '0;
    paint_char <= '0;
    cell_row <= '0;
    cell_col <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_data <= '0;
    steady_feed = 1'b0;
    use_w = SIDE;
    use_h = SIDE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: full clear first so every cell holds a known value
    send_clear();
    send_read(0, 0);
    send_read(SIDE - 1, SIDE - 1);
    send_read(256, 17);
    // filled corner patch with the largest spans, half-unit left edge
    send_draw(SHAPE_FILLED, 297 * ONE_UNIT + 128, 298 * ONE_UNIT, 24'sh7FFFFF, 24'sh7FFFFF,
              8'h41);
    send_read(SIDE - 1, SIDE - 1);
    send_read(298, 297);
    wait_idle();

    // zero width counts as one column, oversize height clamps
    setup_canvas(9'd0, 9'd511, 8'hFF);
    send_clear();
    send_read(SIDE - 1, 0);
    send_read(0, 1);
    // most negative corner: right edge ends left of column zero
    send_draw(SHAPE_OUTLINE, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 8'h00);
    send_read(5, 0);
    wait_idle();

    // oversize width clamps, zero height counts as one row
    setup_canvas(9'd511, 9'd0, 8'h00);
    send_clear();
    send_read(0, SIDE - 1);
    send_read(1, 0);
    wait_idle();

    // small canvas: outline, thin fill, every kind of rejected draw, unused code
    setup_canvas(9'd12, 9'd9, 8'h2E);
    send_clear();
    send_draw(SHAPE_OUTLINE, 2 * ONE_UNIT + 128, ONE_UNIT, 6 * ONE_UNIT, 5 * ONE_UNIT + 64,
              8'h23);
    send_read(3, 5);
    send_read(1, 4);
    send_draw(SHAPE_FILLED, 0, 0, 1, 24'sh7FFFFF, 8'h2A);
    send_draw(SHAPE_FILLED, 0, 0, 0, ONE_UNIT, 8'h55);
    send_draw(SHAPE_OUTLINE, 0, 0, ONE_UNIT, 24'sh800000, 8'h55);
    send_draw(SHAPE_UNKNOWN, 0, 0, 4 * ONE_UNIT, 4 * ONE_UNIT, 8'h55);
    send_unused();
    send_read(8, 0);
    wait_idle();

    // random phases, each with fresh sizes and background
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wreg = $urandom_range(1, 24);
      hreg = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0: begin
          wreg = $urandom_range(301, 511);
          hreg = $urandom_range(0, 3);
        end
        1: begin
          hreg = $urandom_range(301, 511);
          wreg = $urandom_range(0, 3);
        end
        default: ;
      endcase
      steady_feed = ($urandom_range(0, 3) == 0);
      setup_canvas(CFG_W'(wreg), CFG_W'(hreg), CHAR_W'($urandom_range(0, 255)));
      send_clear();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_random_item();
        // one mid-phase hold until the core has caught up
        if (p == 1 && i == ITEMS_PER_PHASE / 2) wait_idle();
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d clears, %0d painted rectangles, %0d rejected draws,",
             sb.clears, sb.draws, sb.rejects);
    $display("%0d cell reads, %0d unused codes, %0d register writes, %0d results checked",
             sb.reads, sb.unused_ops, sb.reg_writes, sb.replies_checked);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("tb_rectangle_raster_canvas_core: clean");
    end else begin
      $display("%0d mismatches, %0d replies outstanding", sb.mismatches,
               sb.pending_replies.size());
      $display("tb_rectangle_raster_canvas_core: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rrc_pkg.sv
rtl/core/rrc_cover.sv
rtl/core/rectangle_raster_canvas_core.sv
rtl/core/rrc_checker.sv
bench/tb_rectangle_raster_canvas_core.sv
